@@ sv/efws_pkg.sv @@
// Shared widths, constants and reset values for the earliest-free-worker scheduler.
package efws_pkg;

   localparam int TIME_W      = 48;
   localparam int DUR_W       = 32;
   localparam int WORKER_W    = 4;
   localparam int COUNT_W     = 5;
   localparam int MAX_WORKERS_DEFAULT = 16;

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 56;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);
   localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};

endpackage

@@ sv/earliest_free_worker_scheduler_unit.sv @@
// Earliest-free-worker scheduler: each job duration goes to the worker that is free first,
// ties to the lowest index, and the worker and start time come back as one transaction.
// A job that finds an unused worker skips the scan; otherwise the free-time memory is scanned
// over all worker_count entries, one entry per cycle; the result is held in an
// output register, so a stalled result only blocks when the next job is ready to finish.
module earliest_free_worker_scheduler_unit #(
   parameter int MAX_WORKERS = efws_pkg::MAX_WORKERS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [efws_pkg::COUNT_W-1:0]     csr_wdata,   // worker_count
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [efws_pkg::REQ_DATA_W-1:0]  req_tdata,   // [31:0] duration
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [efws_pkg::RSP_DATA_W-1:0]  rsp_tdata    // [3:0] worker, [51:4] start_time
);
   import efws_pkg::*;

   localparam int ADDR_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int COUNT_N = $clog2(MAX_WORKERS + 1);

   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_N-1:0]  active_count;
   logic                rd_en, wr_en;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [TIME_W-1:0]   rd_data, wr_data;
   logic [WORKER_W-1:0] rsp_worker;
   logic [TIME_W-1:0]   rsp_start_time;

   // Worker count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // Clamp the count to the range of built workers.
   always_comb begin
      priority if (count_ff == '0) begin
         active_count = COUNT_N'(1);
      end else if (32'(count_ff) > 32'(MAX_WORKERS)) begin
         active_count = COUNT_N'(MAX_WORKERS);
      end else begin
         active_count = COUNT_N'(count_ff);
      end
   end

   efws_time_ram #(
      .DEPTH  (MAX_WORKERS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   efws_sched_ctrl #(
      .ADDR_W  (ADDR_W),
      .COUNT_N (COUNT_N)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .active_count   (active_count),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_duration   (req_tdata[DUR_W-1:0]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_worker     (rsp_worker),
      .rsp_start_time (rsp_start_time),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data)
   );

   assign rsp_tdata = {{(RSP_DATA_W-TIME_W-WORKER_W){1'b0}}, rsp_start_time, rsp_worker};

   // A job is taken only when the sequencer is idle, so it cannot take two in a row.
   a_one_job_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("scheduler accepted a transaction while busy");

   // A result write and a memory read never target the free-time memory at once.
   a_no_read_during_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("free-time read issued during write-back");

   // No result is pending right after reset.
   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

@@ sv/efws_time_ram.sv @@
// Free-time memory: one write port and one read port with registered read data.
module efws_time_ram #(
   parameter int DEPTH  = efws_pkg::MAX_WORKERS_DEFAULT,
   parameter int ADDR_W = 4
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [efws_pkg::TIME_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [efws_pkg::TIME_W-1:0] rd_data
);
   import efws_pkg::*;

   logic [TIME_W-1:0] mem [DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/efws_sched_ctrl.sv @@
// Sequencer: takes an unused worker or scans for the minimum; writes back the new time.
module efws_sched_ctrl #(
   parameter int ADDR_W  = 4,
   parameter int COUNT_N = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [COUNT_N-1:0]           active_count,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [efws_pkg::DUR_W-1:0]   req_duration,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [efws_pkg::WORKER_W-1:0] rsp_worker,
   output logic [efws_pkg::TIME_W-1:0]  rsp_start_time,
   output logic                         rd_en,
   output logic [ADDR_W-1:0]            rd_addr,
   input  logic [efws_pkg::TIME_W-1:0]  rd_data,
   output logic                         wr_en,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic [efws_pkg::TIME_W-1:0]  wr_data
);
   import efws_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [DUR_W-1:0]    dur_ff, dur_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]   best_ff, best_in;
   logic [ADDR_W-1:0]   pick_ff, pick_in;
   logic [COUNT_N-1:0]  used_ff, used_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORKER_W-1:0] rsp_worker_ff, rsp_worker_in;
   logic [TIME_W-1:0]   rsp_time_ff, rsp_time_in;

   logic                scan_last;
   logic [TIME_W:0]     sum_wide;
   logic [TIME_W-1:0]   sum_sat;
   logic                rsp_free;

   assign scan_last = (COUNT_N'(cnt_ff) == active_count - COUNT_N'(1));
   assign sum_wide  = {1'b0, best_ff} + (TIME_W+1)'(dur_ff);
   assign sum_sat   = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_worker     = rsp_worker_ff;
   assign rsp_start_time = rsp_time_ff;

   assign wr_en   = (state_ff == ST_WRITE);
   assign wr_addr = pick_ff;
   assign wr_data = sum_sat;

   // Next-state and datapath control.
   always_comb begin
      state_in      = state_ff;
      dur_in        = dur_ff;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_worker_in = rsp_worker_ff;
      rsp_time_in   = rsp_time_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dur_in = req_duration;
               if (used_ff < active_count) begin
                  // An unused worker takes the job at time zero.
                  pick_in  = used_ff[ADDR_W-1:0];
                  best_in  = '0;
                  used_in  = used_ff + COUNT_N'(1);
                  state_in = ST_WRITE;
               end else begin
                  cnt_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Keep the first strict minimum so ties go to the lowest index.
            if (cnt_ff == '0 || rd_data < best_ff) begin
               best_in = rd_data;
               pick_in = cnt_ff;
            end
            if (scan_last) begin
               state_in = ST_WRITE;
            end else begin
               cnt_in  = cnt_ff + ADDR_W'(1);
               rd_en   = 1'b1;
               rd_addr = cnt_ff + ADDR_W'(1);
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_worker_in = WORKER_W'(pick_ff);
               rsp_time_in   = best_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dur_ff        <= dur_in;
      cnt_ff        <= cnt_in;
      best_ff       <= best_in;
      pick_ff       <= pick_in;
      rsp_worker_ff <= rsp_worker_in;
      rsp_time_ff   <= rsp_time_in;
   end

endmodule
